/* design/lru_lookup_cache_with_age_sweep_unit_assert.svh */
// Assertion macros for the LRU lookup cache.
`ifndef LRU_LOOKUP_CACHE_WITH_AGE_SWEEP_UNIT_ASSERT_SVH
`define LRU_LOOKUP_CACHE_WITH_AGE_SWEEP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset
`define LRUCACHE_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset
`define LRUCACHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRUCACHE_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define LRUCACHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/lrucache_pkg.sv */
// Types, codes and constants shared by the LRU lookup cache.
package lrucache_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SLOT_W  = 6;

    // configuration register indexes and reset values
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_AGE      = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SWEEP_PERIOD = 1'b1;
    localparam logic [31:0] MAX_AGE_RST      = 32'd5000;
    localparam logic [15:0] SWEEP_PERIOD_RST = 16'd100;

    typedef enum logic [2:0] {
        KIND_RELEASE   = 3'd0,
        KIND_HIT       = 3'd1,
        KIND_INSTALLED = 3'd2,
        KIND_NONE      = 3'd3,
        KIND_FAILED    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIT,
        S_SWEEP,
        S_VSCAN,
        S_VFREE,
        S_FINAL
    } t_state;

    // one cache line as stored in the entry memory
    typedef struct packed {
        logic [63:0] stamp;
        logic [15:0] font;
        logic [63:0] key;
        logic [31:0] color;
        logic [31:0] handle;
        logic [15:0] width;
        logic [15:0] height;
    } t_entry;

    // one result item
    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic [31:0]        handle;
        logic [15:0]        width;
        logic [15:0]        height;
        logic               last;
    } t_result;

endpackage

/* design/lru_lookup_cache_with_age_sweep_unit.sv */
// Top level of the LRU lookup cache: fully associative, 32 lines, age sweep on misses.
// A request enters when o_s_axis_tready is high and the block then works on it alone,
// walking the entry memory one line per cycle when not stalled, through a single read
// port and a shared 64-bit subtractor. An empty key goes straight to the final result,
// and a hit ends the lookup at the matching line. A miss runs the lookup over all 32
// lines, a sweep over all lines if the miss count passes sweep_period, the free-slot/LRU
// search up to the first free line, a victim step if none is free and the final result,
// then returns to idle; each release result may stall the sweep or victim step while
// the output register is held by the downstream side. Results leave one at a time,
// releases first and the final result with tlast set. No clearing pass after reset.
`include "lru_lookup_cache_with_age_sweep_unit_assert.svh"

module lru_lookup_cache_with_age_sweep_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [lrucache_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata,
    // request stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // now, font_id, text_key, color, fill_width, fill_height, fill_handle
    input  logic [239:0] i_s_axis_tdata,
    // key_empty, fill_ok
    input  logic [1:0]   i_s_axis_tuser,
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // slot, handle, width, height, zero pad
    output logic [71:0]  o_m_axis_tdata,
    // kind
    output logic [2:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);

    localparam int N     = lrucache_pkg::ENTRIES;
    localparam int IDX_W = lrucache_pkg::IDX_W;

    // control registers
    lrucache_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [N-1:0]         r_valid, n_valid;
    logic [15:0]          r_miss, n_miss;
    logic [31:0]          r_max_age;
    logic [15:0]          r_period;
    logic                 r_out_valid, n_out_valid;

    // request and working registers
    logic [63:0]          r_now;
    logic [15:0]          r_font;
    logic [63:0]          r_key;
    logic [31:0]          r_color;
    logic                 r_empty;
    logic                 r_fill_ok;
    logic [15:0]          r_fill_w, r_fill_h;
    logic [31:0]          r_fill_handle;
    logic [IDX_W-1:0]     r_oldest, n_oldest;
    logic [63:0]          r_oldest_t, n_oldest_t;
    lrucache_pkg::t_result r_fin, n_fin;
    lrucache_pkg::t_result r_out, n_out;

    // entry memory
    lrucache_pkg::t_entry r_mem [N];
    lrucache_pkg::t_entry r_rdata;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    lrucache_pkg::t_entry mem_wdata;

    // shared datapath
    logic                 in_xfer;
    logic                 out_free;
    logic                 idx_last;
    logic                 hit_match;
    logic [63:0]          alu_a, alu_b;
    logic [64:0]          alu_res;
    logic                 older;
    logic                 aged;
    logic [16:0]          cnt_inc;
    logic                 do_sweep;
    logic                 rel_nz;
    logic                 sweep_go;
    logic                 vfree_go;
    logic [IDX_W-1:0]     victim;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign idx_last = (r_idx == IDX_W'(N - 1));

    assign hit_match = r_valid[r_idx] && (r_rdata.font == r_font) &&
                       (r_rdata.key == r_key) && (r_rdata.color == r_color);

    // shared subtractor: age during the sweep, time order during the LRU search
    assign alu_a   = (r_state == lrucache_pkg::S_SWEEP) ? r_now : r_rdata.stamp;
    assign alu_b   = (r_state == lrucache_pkg::S_SWEEP) ? r_rdata.stamp : r_oldest_t;
    assign alu_res = {1'b0, alu_a} - {1'b0, alu_b};
    assign older   = alu_res[64];
    assign aged    = r_valid[r_idx] &&
                     ((|alu_res[63:32]) || (alu_res[31:0] > r_max_age));

    assign cnt_inc  = {1'b0, r_miss} + 17'd1;
    assign do_sweep = cnt_inc > {1'b0, r_period};

    assign rel_nz   = (r_rdata.handle != 32'd0);
    assign sweep_go = !aged || !rel_nz || out_free;
    assign vfree_go = !rel_nz || out_free;
    assign victim   = older ? r_idx : r_oldest;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrucache_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = i_s_axis_tuser[0] ? lrucache_pkg::S_FINAL : lrucache_pkg::S_HIT;
                end
            end
            lrucache_pkg::S_HIT: begin
                if (hit_match) begin
                    n_state = lrucache_pkg::S_FINAL;
                end else if (idx_last) begin
                    n_state = do_sweep ? lrucache_pkg::S_SWEEP : lrucache_pkg::S_VSCAN;
                end
            end
            lrucache_pkg::S_SWEEP: begin
                if (sweep_go && idx_last) begin
                    n_state = lrucache_pkg::S_VSCAN;
                end
            end
            lrucache_pkg::S_VSCAN: begin
                if (!r_valid[r_idx]) begin
                    n_state = lrucache_pkg::S_FINAL;
                end else if (idx_last) begin
                    n_state = lrucache_pkg::S_VFREE;
                end
            end
            lrucache_pkg::S_VFREE: begin
                if (vfree_go) begin
                    n_state = lrucache_pkg::S_FINAL;
                end
            end
            lrucache_pkg::S_FINAL: begin
                if (out_free) begin
                    n_state = lrucache_pkg::S_IDLE;
                end
            end
            default: n_state = lrucache_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs per state
    always_comb begin
        logic             fill_now;
        logic [IDX_W-1:0] fill_slot;
        logic             rel_now;
        logic [IDX_W-1:0] rel_slot;

        fill_now   = 1'b0;
        fill_slot  = r_idx;
        rel_now    = 1'b0;
        rel_slot   = r_idx;
        n_idx      = r_idx;
        n_valid    = r_valid;
        n_miss     = r_miss;
        n_oldest   = r_oldest;
        n_oldest_t = r_oldest_t;
        n_fin      = r_fin;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = r_rdata;

        unique case (r_state)
            lrucache_pkg::S_IDLE: begin
                n_idx = '0;
                n_fin = '{kind: lrucache_pkg::KIND_NONE, slot: '0, handle: '0,
                          width: '0, height: '0, last: 1'b1};
            end
            lrucache_pkg::S_HIT: begin
                if (hit_match) begin
                    // refresh the line's time stamp and return its payload
                    mem_we          = 1'b1;
                    mem_wdata.stamp = r_now;
                    n_fin = '{kind: lrucache_pkg::KIND_HIT,
                              slot: lrucache_pkg::SLOT_W'(r_idx),
                              handle: r_rdata.handle, width: r_rdata.width,
                              height: r_rdata.height, last: 1'b1};
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                    if (idx_last) begin
                        n_idx      = '0;
                        n_oldest   = '0;
                        n_oldest_t = '1;
                        n_miss     = do_sweep ? 16'd0 : cnt_inc[15:0];
                    end
                end
            end
            lrucache_pkg::S_SWEEP: begin
                if (sweep_go) begin
                    if (aged) begin
                        n_valid[r_idx] = 1'b0;
                        rel_now        = rel_nz;
                    end
                    n_idx = idx_last ? '0 : r_idx + IDX_W'(1);
                end
            end
            lrucache_pkg::S_VSCAN: begin
                if (!r_valid[r_idx]) begin
                    fill_now  = 1'b1;
                    fill_slot = r_idx;
                end else begin
                    if (older) begin
                        n_oldest   = r_idx;
                        n_oldest_t = r_rdata.stamp;
                    end
                    // on the last line, point the read port at the victim
                    n_idx = idx_last ? victim : r_idx + IDX_W'(1);
                end
            end
            lrucache_pkg::S_VFREE: begin
                if (vfree_go) begin
                    n_valid[r_oldest] = 1'b0;
                    rel_now           = rel_nz;
                    rel_slot          = r_oldest;
                    fill_now          = 1'b1;
                    fill_slot         = r_oldest;
                end
            end
            lrucache_pkg::S_FINAL: begin
                n_idx = '0;
            end
            default: n_idx = '0;
        endcase

        // install the fill data, or report a failed fill
        if (fill_now) begin
            if (r_fill_ok) begin
                mem_we             = 1'b1;
                mem_waddr          = fill_slot;
                mem_wdata          = '{stamp: r_now, font: r_font, key: r_key,
                                       color: r_color, handle: r_fill_handle,
                                       width: r_fill_w, height: r_fill_h};
                n_valid[fill_slot] = 1'b1;
                n_fin = '{kind: lrucache_pkg::KIND_INSTALLED,
                          slot: lrucache_pkg::SLOT_W'(fill_slot),
                          handle: r_fill_handle, width: r_fill_w,
                          height: r_fill_h, last: 1'b1};
            end else begin
                n_fin = '{kind: lrucache_pkg::KIND_FAILED,
                          slot: lrucache_pkg::SLOT_W'(fill_slot),
                          handle: '0, width: '0, height: '0, last: 1'b1};
            end
        end

        // output register: release results, then the final one
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        if (rel_now) begin
            n_out       = '{kind: lrucache_pkg::KIND_RELEASE,
                            slot: lrucache_pkg::SLOT_W'(rel_slot),
                            handle: r_rdata.handle, width: '0, height: '0, last: 1'b0};
            n_out_valid = 1'b1;
        end else if (r_state == lrucache_pkg::S_FINAL && out_free) begin
            n_out       = r_fin;
            n_out_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrucache_pkg::S_IDLE;
            r_idx       <= '0;
            r_valid     <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
            r_max_age   <= lrucache_pkg::MAX_AGE_RST;
            r_period    <= lrucache_pkg::SWEEP_PERIOD_RST;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_valid     <= n_valid;
            r_miss      <= n_miss;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    lrucache_pkg::CFG_MAX_AGE:      r_max_age <= i_cfg_wdata;
                    lrucache_pkg::CFG_SWEEP_PERIOD: r_period  <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // request capture and working payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_now         <= i_s_axis_tdata[63:0];
            r_font        <= i_s_axis_tdata[79:64];
            r_key         <= i_s_axis_tdata[143:80];
            r_color       <= i_s_axis_tdata[175:144];
            r_fill_w      <= i_s_axis_tdata[191:176];
            r_fill_h      <= i_s_axis_tdata[207:192];
            r_fill_handle <= i_s_axis_tdata[239:208];
            r_empty       <= i_s_axis_tuser[0];
            r_fill_ok     <= i_s_axis_tuser[1];
        end
        r_oldest   <= n_oldest;
        r_oldest_t <= n_oldest_t;
        r_fin      <= n_fin;
        r_out      <= n_out;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[n_idx];
    end

    assign o_s_axis_tready = (r_state == lrucache_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.height, r_out.width, r_out.handle, r_out.slot};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;

    // checks
    `LRUCACHE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_xfer, !o_s_axis_tready, "request accepted while busy")
    `LRUCACHE_ASSERT(a_last_marks_final, i_clk, i_rst_n, r_out_valid, r_out.last == (r_out.kind != lrucache_pkg::KIND_RELEASE), "tlast does not match kind")
    `LRUCACHE_ASSERT(a_release_nonzero, i_clk, i_rst_n, r_out_valid && r_out.kind == lrucache_pkg::KIND_RELEASE, r_out.handle != 32'd0 && r_out.width == 16'd0 && r_out.height == 16'd0, "bad release result")
    `LRUCACHE_ASSERT(a_empty_none, i_clk, i_rst_n, r_state == lrucache_pkg::S_FINAL && r_empty, r_fin.kind == lrucache_pkg::KIND_NONE && r_fin.handle == 32'd0, "empty key gave a result other than none")

endmodule
